>>> src/pjn_pkg.sv
// Shared types, sizes and helper functions for the polyline join normal block.
// Used by the controller, the datapath and the normalizer.
`timescale 1ns / 1ps
`default_nettype none
package pjn_pkg;

    localparam int MAX_VERTS = 64;
    localparam int ADDR_W    = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);

    localparam int PT_W      = 32;
    localparam int DIR_W     = 16;
    localparam int DIFF_W    = PT_W + 1;
    localparam int SUM_W     = DIR_W + 1;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REVERSE  = 2'd0,
        REG_OPEN     = 2'd1,
        REG_INTERIOR = 2'd2
    } pjn_reg_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] x;
    } pjn_vec_t;

    typedef struct packed {
        logic              pt_we;
        logic [ADDR_W-1:0] pt_waddr;
        logic [ADDR_W-1:0] pt_raddr;
        logic              dir_we;
        logic [ADDR_W-1:0] dir_waddr;
        logic [ADDR_W-1:0] dir_raddr;
        logic              lat_ord;
        logic              start_edge;
        logic              lat_dir_a;
        logic              lat_dir_b;
        logic              lat_vertex;
        logic              calc_dot;
        logic              decide;
        logic              lat_joint;
        logic              load_out;
        logic              use_a;
        logic              cap;
        logic              last;
        logic              ovf;
        logic              neg;
    } pjn_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic need_norm;
    } pjn_sts_t;

    // Quarter turn anticlockwise, negated for the interior side
    function automatic pjn_vec_t rot_normal(input pjn_vec_t v, input logic neg);
        pjn_vec_t r;
        if (neg)
        begin
            r.x = v.y;
            r.y = -v.x;
        end
        else
        begin
            r.x = -v.y;
            r.y = v.x;
        end
        return r;
    endfunction

    function automatic pjn_vec_t scale_sign(input pjn_vec_t v, input logic neg);
        pjn_vec_t r;
        if (neg)
        begin
            r.x = -v.x;
            r.y = -v.y;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/pjn_norm.sv
// Iterative vector normalizer: scale, sum of squares, bit-serial square root,
// restoring division per component. Depends on pjn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pjn_norm
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [pjn_pkg::DIFF_W-1:0]  in_x,
    input  wire logic signed [pjn_pkg::DIFF_W-1:0]  in_y,
    output logic                                    done,
    output pjn_pkg::pjn_vec_t                       res
);

    localparam int MAG_W = pjn_pkg::DIFF_W;
    localparam int SQ_W  = 60;
    localparam int RAD_W = 62;
    localparam int LEN_W = 31;
    localparam int NUM_W = 46;
    localparam int Q_W   = 15;
    localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

    typedef enum logic [3:0] {
        N_IDLE, N_SCALE, N_SQX, N_SQY, N_SUM, N_SQRT, N_DLOAD, N_DIV, N_DONE
    } nstate_t;

    nstate_t state_reg, state_next;

    logic [MAG_W-1:0] mx_reg, my_reg;
    logic             nx_reg, ny_reg;
    logic [SQ_W-1:0]  prod_reg;
    logic [RAD_W-1:0] rad_reg, root_reg, bit_reg;
    logic [NUM_W-1:0] num_reg, den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [3:0]       cnt_reg;
    logic             sel_reg;

    logic [MAG_W-1:0] ax, ay, mm;
    logic [RAD_W-1:0] trial;
    logic             sq_ge, div_ge;
    logic [Q_W-1:0]   q_full, q_clip;
    logic [pjn_pkg::DIR_W-1:0] q_signed;

    assign ax = in_x[MAG_W-1] ? MAG_W'(-in_x) : MAG_W'(in_x);
    assign ay = in_y[MAG_W-1] ? MAG_W'(-in_y) : MAG_W'(in_y);
    assign mm = (mx_reg > my_reg) ? mx_reg : my_reg;

    assign trial  = root_reg + bit_reg;
    assign sq_ge  = rad_reg >= trial;
    assign div_ge = num_reg >= den_reg;
    assign q_full = {q_reg[Q_W-2:0], div_ge};
    assign q_clip = (q_full > Q_ONE) ? Q_ONE : q_full;
    assign q_signed = (sel_reg ? ny_reg : nx_reg) ? -{1'b0, q_clip} : {1'b0, q_clip};

    assign done = (state_reg == N_DONE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = (ax == '0 && ay == '0) ? N_DONE : N_SCALE;
                end
            end
            N_SCALE:
            begin
                if (mm[MAG_W-1:30] == '0 && mm[29])
                begin
                    state_next = N_SQX;
                end
            end
            N_SQX:   state_next = N_SQY;
            N_SQY:   state_next = N_SUM;
            N_SUM:   state_next = N_SQRT;
            N_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = N_DLOAD;
                end
            end
            N_DLOAD: state_next = N_DIV;
            N_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sel_reg ? N_DONE : N_DLOAD;
                end
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    mx_reg  <= ax;
                    my_reg  <= ay;
                    nx_reg  <= in_x[MAG_W-1];
                    ny_reg  <= in_y[MAG_W-1];
                    sel_reg <= 1'b0;
                    res     <= '0;
                end
            end
            N_SCALE:
            begin
                if (mm[MAG_W-1:30] != '0)
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                end
                else if (!mm[29])
                begin
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                end
            end
            N_SQX:
            begin
                prod_reg <= mx_reg[29:0] * mx_reg[29:0];
            end
            N_SQY:
            begin
                rad_reg  <= RAD_W'(prod_reg);
                prod_reg <= my_reg[29:0] * my_reg[29:0];
            end
            N_SUM:
            begin
                rad_reg  <= rad_reg + RAD_W'(prod_reg);
                root_reg <= '0;
                bit_reg  <= RAD_W'(1) << 60;
            end
            N_SQRT:
            begin
                if (sq_ge)
                begin
                    rad_reg  <= rad_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DLOAD:
            begin
                num_reg <= NUM_W'({sel_reg ? my_reg[29:0] : mx_reg[29:0], 14'd0})
                         + NUM_W'(root_reg[LEN_W-1:1]);
                den_reg <= NUM_W'({root_reg[LEN_W-1:0], 14'd0});
                q_reg   <= '0;
                cnt_reg <= 4'd14;
            end
            N_DIV:
            begin
                if (div_ge)
                begin
                    num_reg <= num_reg - den_reg;
                end
                den_reg <= den_reg >> 1;
                q_reg   <= q_full;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    if (sel_reg)
                    begin
                        res.y <= q_signed;
                    end
                    else
                    begin
                        res.x <= q_signed;
                    end
                    sel_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/pjn_dp.sv
// Datapath: point and direction memories, joint arithmetic, result registers.
// Instantiates pjn_norm; uses pjn_pkg types and helpers.
`timescale 1ns / 1ps
`default_nettype none
module pjn_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pjn_pkg::pjn_cmd_t                   cmd,
    input  wire logic signed [pjn_pkg::PT_W-1:0]     point_x,
    input  wire logic signed [pjn_pkg::PT_W-1:0]     point_y,
    output pjn_pkg::pjn_sts_t                        sts,
    output logic signed [pjn_pkg::PT_W-1:0]          vertex_x,
    output logic signed [pjn_pkg::PT_W-1:0]          vertex_y,
    output logic signed [pjn_pkg::DIR_W-1:0]         edge_dir_x,
    output logic signed [pjn_pkg::DIR_W-1:0]         edge_dir_y,
    output logic signed [pjn_pkg::DIR_W-1:0]         edge_norm_x,
    output logic signed [pjn_pkg::DIR_W-1:0]         edge_norm_y,
    output logic signed [pjn_pkg::DIR_W-1:0]         joint_norm_x,
    output logic signed [pjn_pkg::DIR_W-1:0]         joint_norm_y,
    output logic                                     is_cap,
    output logic                                     overflow,
    output logic                                     last_join
);

    localparam int PW = pjn_pkg::PT_W;
    localparam int DW = pjn_pkg::DIFF_W;
    localparam int SW = pjn_pkg::SUM_W;
    localparam int DOT_W = 2 * pjn_pkg::DIR_W + 1;
    localparam logic signed [DOT_W-1:0] DOT_LIM = -33'sd268435456;

    logic [PW-1:0] pt_x_mem [pjn_pkg::MAX_VERTS];
    logic [PW-1:0] pt_y_mem [pjn_pkg::MAX_VERTS];
    pjn_pkg::pjn_vec_t dir_mem [pjn_pkg::MAX_VERTS];

    logic signed [PW-1:0] pt_rx_reg, pt_ry_reg, ord_x_reg, ord_y_reg;
    logic signed [PW-1:0] vtx_x_reg, vtx_y_reg;
    pjn_pkg::pjn_vec_t dir_rd_reg, dir_a_reg, dir_b_reg, jnt_reg;
    logic signed [2*pjn_pkg::DIR_W-1:0] p1_reg, p2_reg;

    pjn_pkg::pjn_vec_t nrm_a, nrm_b, eff, nrm_eff, a_scaled, norm_res;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [DOT_W-1:0] dot;
    logic opposite;
    logic norm_start, norm_done;
    logic signed [DW-1:0] nin_x, nin_y;

    always_ff @(posedge clk)
    begin
        if (cmd.pt_we)
        begin
            pt_x_mem[cmd.pt_waddr] <= point_x;
            pt_y_mem[cmd.pt_waddr] <= point_y;
        end
        pt_rx_reg <= pt_x_mem[cmd.pt_raddr];
        pt_ry_reg <= pt_y_mem[cmd.pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dir_we)
        begin
            dir_mem[cmd.dir_waddr] <= norm_res;
        end
        dir_rd_reg <= dir_mem[cmd.dir_raddr];
    end

    assign nrm_a    = pjn_pkg::rot_normal(dir_a_reg, cmd.neg);
    assign nrm_b    = pjn_pkg::rot_normal(dir_b_reg, cmd.neg);
    assign eff      = cmd.use_a ? dir_a_reg : dir_b_reg;
    assign nrm_eff  = pjn_pkg::rot_normal(eff, cmd.neg);
    assign a_scaled = pjn_pkg::scale_sign(dir_a_reg, cmd.neg);

    assign sum_x = SW'(nrm_a.x) + SW'(nrm_b.x);
    assign sum_y = SW'(nrm_a.y) + SW'(nrm_b.y);
    // normal dot equals direction dot: the quarter turn preserves it
    assign dot   = DOT_W'(p1_reg) + DOT_W'(p2_reg);
    assign opposite = (sum_x == '0 && sum_y == '0) || (dot <= DOT_LIM);

    assign sts.need_norm = !cmd.cap && !opposite;
    assign sts.norm_done = norm_done;

    assign norm_start = cmd.start_edge || (cmd.decide && sts.need_norm);
    assign nin_x = cmd.decide ? DW'(sum_x) : (DW'(pt_rx_reg) - DW'(ord_x_reg));
    assign nin_y = cmd.decide ? DW'(sum_y) : (DW'(pt_ry_reg) - DW'(ord_y_reg));

    pjn_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .in_x  (nin_x),
        .in_y  (nin_y),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.lat_ord)
        begin
            ord_x_reg <= pt_rx_reg;
            ord_y_reg <= pt_ry_reg;
        end
        if (cmd.lat_vertex)
        begin
            vtx_x_reg <= pt_rx_reg;
            vtx_y_reg <= pt_ry_reg;
        end
        if (cmd.lat_dir_a)
        begin
            dir_a_reg <= dir_rd_reg;
        end
        if (cmd.lat_dir_b)
        begin
            dir_b_reg <= dir_rd_reg;
        end
        if (cmd.calc_dot)
        begin
            p1_reg <= dir_a_reg.x * dir_b_reg.x;
            p2_reg <= dir_a_reg.y * dir_b_reg.y;
        end
        if (cmd.decide)
        begin
            if (cmd.cap)
            begin
                jnt_reg <= nrm_eff;
            end
            else if (opposite)
            begin
                jnt_reg <= a_scaled;
            end
        end
        if (cmd.lat_joint)
        begin
            jnt_reg <= norm_res;
        end
        if (cmd.load_out)
        begin
            vertex_x     <= vtx_x_reg;
            vertex_y     <= vtx_y_reg;
            edge_dir_x   <= eff.x;
            edge_dir_y   <= eff.y;
            edge_norm_x  <= nrm_eff.x;
            edge_norm_y  <= nrm_eff.y;
            joint_norm_x <= jnt_reg.x;
            joint_norm_y <= jnt_reg.y;
            is_cap       <= cmd.cap;
            overflow     <= cmd.ovf;
            last_join    <= cmd.last;
        end
    end

endmodule
`default_nettype wire

>>> src/pjn_ctrl.sv
// Controller: point count, configuration registers and the sequencer for the
// edge and joint passes. Uses pjn_pkg; drives pjn_dp through pjn_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module pjn_ctrl
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              final_point,
    input  wire logic                              cfg_we,
    input  wire logic [pjn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic                              cfg_data,
    input  wire pjn_pkg::pjn_sts_t                 sts,
    output pjn_pkg::pjn_cmd_t                      cmd,
    output logic                                   busy,
    output logic                                   done
);

    localparam int AW = pjn_pkg::ADDR_W;
    localparam int CW = pjn_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD0, S_A_RD1, S_A_RD2, S_A_WAIT,
        S_B_RD0, S_B_RD1, S_B_RD2, S_B_DOT, S_B_DEC, S_B_WAIT, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic rev_reg, rev_next, open_reg, open_next, neg_reg, neg_next;
    logic done_reg, done_next;

    logic [AW-1:0] top, nxt, prv;
    logic accept, is_top;

    function automatic logic [AW-1:0] order(input logic [AW-1:0] x, input logic [AW-1:0] t,
                                            input logic r);
        return r ? AW'(t - x) : x;
    endfunction

    assign top    = AW'(cnt_reg - CW'(1));
    assign is_top = (idx_reg == top);
    assign nxt    = is_top ? '0 : AW'(idx_reg + AW'(1));
    assign prv    = (idx_reg == '0) ? top : AW'(idx_reg - AW'(1));
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;

    always_comb
    begin
        cmd = '0;
        cmd.pt_waddr = cnt_reg[AW-1:0];
        cmd.dir_waddr = idx_reg;
        cmd.use_a = open_reg && is_top && (idx_reg != '0);
        cmd.cap   = open_reg && ((idx_reg == '0) || is_top);
        cmd.last  = is_top;
        cmd.ovf   = ovf_reg;
        cmd.neg   = neg_reg;
        cmd.pt_we = accept && (cnt_reg < CW'(pjn_pkg::MAX_VERTS));

        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        rev_next   = rev_reg;
        open_next  = open_reg;
        neg_next   = neg_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                pjn_pkg::REG_REVERSE:  rev_next  = cfg_data;
                pjn_pkg::REG_OPEN:     open_next = cfg_data;
                pjn_pkg::REG_INTERIOR: neg_next  = cfg_data;
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.pt_we)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_point)
                    begin
                        idx_next   = '0;
                        state_next = S_A_RD0;
                    end
                end
            end
            S_A_RD0:
            begin
                cmd.pt_raddr = order(idx_reg, top, rev_reg);
                state_next   = S_A_RD1;
            end
            S_A_RD1:
            begin
                cmd.lat_ord  = 1'b1;
                cmd.pt_raddr = order(nxt, top, rev_reg);
                state_next   = S_A_RD2;
            end
            S_A_RD2:
            begin
                cmd.start_edge = 1'b1;
                state_next     = S_A_WAIT;
            end
            S_A_WAIT:
            begin
                if (sts.norm_done)
                begin
                    cmd.dir_we = 1'b1;
                    idx_next   = is_top ? '0 : nxt;
                    state_next = is_top ? S_B_RD0 : S_A_RD0;
                end
            end
            S_B_RD0:
            begin
                cmd.dir_raddr = prv;
                cmd.pt_raddr  = order(idx_reg, top, rev_reg);
                state_next    = S_B_RD1;
            end
            S_B_RD1:
            begin
                cmd.lat_dir_a  = 1'b1;
                cmd.lat_vertex = 1'b1;
                cmd.dir_raddr  = idx_reg;
                state_next     = S_B_RD2;
            end
            S_B_RD2:
            begin
                cmd.lat_dir_b = 1'b1;
                state_next    = S_B_DOT;
            end
            S_B_DOT:
            begin
                cmd.calc_dot = 1'b1;
                state_next   = S_B_DEC;
            end
            S_B_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_norm ? S_B_WAIT : S_EMIT;
            end
            S_B_WAIT:
            begin
                if (sts.norm_done)
                begin
                    cmd.lat_joint = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.load_out = 1'b1;
                done_next    = 1'b1;
                if (is_top)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = nxt;
                    state_next = S_B_RD0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            rev_reg   <= 1'b0;
            open_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            rev_reg   <= rev_next;
            open_reg  <= open_next;
            neg_reg   <= neg_next;
            done_reg  <= done_next;
        end
    end

`ifndef SYNTHESIS
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pt_we |-> cnt_reg < CW'(pjn_pkg::MAX_VERTS))
        else $error("point store written past capacity");

    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EMIT))
        else $error("result strobe without emit step");

    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && is_top) |=> (cnt_reg == '0 && !ovf_reg && state_reg == S_IDLE))
        else $error("run end did not clear count");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (idx_reg <= top && cnt_reg != '0))
        else $error("join index beyond stored points");
`endif

endmodule
`default_nettype wire

>>> src/polyline_join_normals.sv
// Stores a point per accepted start, up to 64 (later ones set overflow); the final point
// triggers one result per stored point. An edge pass normalizes every edge, then a joint
// pass emits the joins, normalizing the joint sum when it is needed.
// Throughput: one point per cycle while loading; no point is taken while busy.
// Receiver cannot stall: done pulses one cycle per result. Reset: async active-low
// clears count, overflow and configuration; point memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module polyline_join_normals
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [pjn_pkg::PT_W-1:0]   point_x,
    input  wire logic signed [pjn_pkg::PT_W-1:0]   point_y,
    input  wire logic                              final_point,
    input  wire logic                              cfg_we,
    input  wire logic [pjn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic                              cfg_data,
    output logic                                   done,
    output logic signed [pjn_pkg::PT_W-1:0]        vertex_x,
    output logic signed [pjn_pkg::PT_W-1:0]        vertex_y,
    output logic signed [pjn_pkg::DIR_W-1:0]       edge_dir_x,
    output logic signed [pjn_pkg::DIR_W-1:0]       edge_dir_y,
    output logic signed [pjn_pkg::DIR_W-1:0]       edge_norm_x,
    output logic signed [pjn_pkg::DIR_W-1:0]       edge_norm_y,
    output logic signed [pjn_pkg::DIR_W-1:0]       joint_norm_x,
    output logic signed [pjn_pkg::DIR_W-1:0]       joint_norm_y,
    output logic                                   is_cap,
    output logic                                   overflow,
    output logic                                   last_join
);

    pjn_pkg::pjn_cmd_t cmd;
    pjn_pkg::pjn_sts_t sts;

    pjn_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .final_point (final_point),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done)
    );

    pjn_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .point_x      (point_x),
        .point_y      (point_y),
        .sts          (sts),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .edge_dir_x   (edge_dir_x),
        .edge_dir_y   (edge_dir_y),
        .edge_norm_x  (edge_norm_x),
        .edge_norm_y  (edge_norm_y),
        .joint_norm_x (joint_norm_x),
        .joint_norm_y (joint_norm_y),
        .is_cap       (is_cap),
        .overflow     (overflow),
        .last_join    (last_join)
    );

endmodule
`default_nettype wire

>>> test/polyline_join_normals_test.sv
// Self-checking testbench for polyline_join_normals: closed, open, reversed and interior runs.
// Depends on pjn_pkg and the polyline_join_normals RTL; predicts every join internally.
`timescale 1ns / 1ps
module polyline_join_normals_test;

    localparam logic [pjn_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        int x;
        int y;
        bit fin;
    } point_t;

    typedef struct {
        logic signed [31:0] vx, vy;
        logic signed [15:0] dx, dy, nx, ny, jx, jy;
        logic cap, ovf, last;
    } join_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic final_point = 1'b0;
    logic cfg_we = 1'b0;
    logic [pjn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic cfg_data = 1'b0;
    logic busy, done, is_cap, overflow, last_join;
    logic signed [31:0] vertex_x, vertex_y;
    logic signed [15:0] edge_dir_x, edge_dir_y, edge_norm_x, edge_norm_y;
    logic signed [15:0] joint_norm_x, joint_norm_y;

    polyline_join_normals dut (.*);

    always #4 clk = ~clk;

    point_t pending_points[$];
    join_t expected_joins[$];
    int idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    bit transfer_seen = 0;

    // predictor state
    int store_x[pjn_pkg::MAX_VERTS], store_y[pjn_pkg::MAX_VERTS];
    int stored = 0;
    bit dropped = 0;
    bit rev_cfg = 0, open_cfg = 0, inner_cfg = 0;

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_dir(input longint dx, input longint dy,
                                     output int ox, output int oy);
        longint unsigned mx, my, mm, len, qx, qy;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        if (mx == 0 && my == 0)
        begin
            ox = 0;
            oy = 0;
            return;
        end
        mm = (mx > my) ? mx : my;
        while (mm >= (64'd1 << 30))
        begin
            mx >>= 1; my >>= 1; mm >>= 1;
        end
        while (mm < (64'd1 << 29))
        begin
            mx <<= 1; my <<= 1; mm <<= 1;
        end
        len = isqrt(mx * mx + my * my);
        qx = (mx * 16384 + len / 2) / len;
        qy = (my * 16384 + len / 2) / len;
        if (qx > 16384) qx = 16384;
        if (qy > 16384) qy = 16384;
        ox = (dx < 0) ? -int'(qx) : int'(qx);
        oy = (dy < 0) ? -int'(qy) : int'(qy);
    endfunction

    // Store one point; on the final point work out every join of the run.
    task automatic predict_joins(input point_t p);
        int n, top, s, k, nx, pv, first, stop;
        int ox[pjn_pkg::MAX_VERTS], oy[pjn_pkg::MAX_VERTS];
        int ux[pjn_pkg::MAX_VERTS], uy[pjn_pkg::MAX_VERTS];
        int ex[pjn_pkg::MAX_VERTS], ey[pjn_pkg::MAX_VERTS];
        int jx[pjn_pkg::MAX_VERTS], jy[pjn_pkg::MAX_VERTS];
        longint sx, sy, dot;
        join_t j;
        if (stored < pjn_pkg::MAX_VERTS)
        begin
            store_x[stored] = p.x;
            store_y[stored] = p.y;
            stored++;
        end
        else
            dropped = 1;
        if (!p.fin)
            return;
        n = stored;
        top = n - 1;
        s = inner_cfg ? -1 : 1;
        for (int i = 0; i < n; i++)
        begin
            k = rev_cfg ? top - i : i;
            ox[i] = store_x[k];
            oy[i] = store_y[k];
        end
        for (int i = 0; i < n; i++)
        begin
            nx = (i + 1 == n) ? 0 : i + 1;
            unit_dir(longint'(ox[nx]) - ox[i], longint'(oy[nx]) - oy[i], ux[i], uy[i]);
            ex[i] = -uy[i] * s;
            ey[i] = ux[i] * s;
        end
        first = 0;
        stop = n;
        if (open_cfg)
        begin
            if (n >= 2)
            begin
                ux[top] = ux[top-1]; uy[top] = uy[top-1];
                ex[top] = ex[top-1]; ey[top] = ey[top-1];
            end
            else
            begin
                ux[0] = 0; uy[0] = 0; ex[0] = 0; ey[0] = 0;
            end
            jx[0] = ex[0]; jy[0] = ey[0];
            jx[top] = ex[top]; jy[top] = ey[top];
            first = 1;
            stop = top;
        end
        for (int i = first; i < stop; i++)
        begin
            pv = (i == 0) ? top : i - 1;
            sx = longint'(ex[pv]) + ex[i];
            sy = longint'(ey[pv]) + ey[i];
            dot = longint'(ex[pv]) * ex[i] + longint'(ey[pv]) * ey[i];
            // opposite edges: fall back to the previous direction
            if ((sx == 0 && sy == 0) || dot <= -(64'sd1 <<< 28))
            begin
                jx[i] = ux[pv] * s;
                jy[i] = uy[pv] * s;
            end
            else
                unit_dir(sx, sy, jx[i], jy[i]);
        end
        for (int i = 0; i < n; i++)
        begin
            j.vx = ox[i]; j.vy = oy[i];
            j.dx = ux[i][15:0]; j.dy = uy[i][15:0];
            j.nx = ex[i][15:0]; j.ny = ey[i][15:0];
            j.jx = jx[i][15:0]; j.jy = jy[i][15:0];
            j.cap = open_cfg && (i == 0 || i == top);
            j.ovf = dropped;
            j.last = (i == top);
            expected_joins.push_back(j);
        end
        stored = 0;
        dropped = 0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: record accepted points and compare each join strobe.
    always @(posedge clk)
    begin
        join_t j;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("polyline_join_normals verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_joins('{x: point_x, y: point_y, fin: final_point});
                transfer_seen = 1;
            end
            if (done)
            begin
                if (expected_joins.size() == 0)
                begin
                    $error("unexpected join result");
                    errors++;
                end
                else
                begin
                    j = expected_joins.pop_front();
                    check_field("vertex_x", j.vx, vertex_x);
                    check_field("vertex_y", j.vy, vertex_y);
                    check_field("edge_dir_x", j.dx, edge_dir_x);
                    check_field("edge_dir_y", j.dy, edge_dir_y);
                    check_field("edge_norm_x", j.nx, edge_norm_x);
                    check_field("edge_norm_y", j.ny, edge_norm_y);
                    check_field("joint_norm_x", j.jx, joint_norm_x);
                    check_field("joint_norm_y", j.jy, joint_norm_y);
                    check_field("is_cap", j.cap, is_cap);
                    check_field("overflow", j.ovf, overflow);
                    check_field("last_join", j.last, last_join);
                end
            end
        end
    end

    // Driver: hold the current point until transfer, then advance or idle.
    always @(negedge clk)
    begin
        point_t p;
        if (rst_n && !(start && !transfer_seen))
        begin
            if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                p = pending_points.pop_front();
                point_x <= p.x;
                point_y <= p.y;
                final_point <= p.fin;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
        transfer_seen = 0;
    end

    task automatic write_reg(input logic [pjn_pkg::CFG_IDX_W-1:0] idx, input bit v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            pjn_pkg::REG_REVERSE:  rev_cfg = v;
            pjn_pkg::REG_OPEN:     open_cfg = v;
            pjn_pkg::REG_INTERIOR: inner_cfg = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_point(input int x, input int y, input bit fin);
        pending_points.push_back('{x: x, y: y, fin: fin});
    endtask

    task automatic add_directed();
        add_point(32'sh0001_0000, -32'sh0002_0000, 1);     // lone point
        add_point(0, 0, 0);
        add_point(32'sh0003_0000, 32'sh0004_0000, 1);
        add_point(32'h7fff_ffff, 32'h7fff_ffff, 0);        // coordinate extremes
        add_point(32'h8000_0000, 32'h8000_0000, 0);
        add_point(32'h7fff_ffff, 32'h8000_0000, 1);
        add_point(32'sh0005_0000, 32'sh0005_0000, 0);      // zero-length edge
        add_point(32'sh0005_0000, 32'sh0005_0000, 0);
        add_point(32'sh0009_0000, 32'sh0007_0000, 1);
        add_point(0, 0, 0);                                // doubling back
        add_point(32'sh0001_0000, 0, 0);
        add_point(0, 0, 1);
        add_point(0, 0, 0);                                // straight line
        add_point(32'sh0001_0000, 32'sh0000_8000, 0);
        add_point(32'sh0002_0000, 32'sh0001_0000, 1);
        add_point(-32'sh0001_0000, 0, 0);                  // square
        add_point(0, -32'sh0001_0000, 0);
        add_point(32'sh0001_0000, 0, 0);
        add_point(0, 32'sh0001_0000, 1);
    endtask

    task automatic add_run(input int len);
        int x, y, kind, step;
        kind = $urandom_range(9);
        x = $urandom;
        y = $urandom;
        step = 1 << $urandom_range(24, 4);
        for (int i = 0; i < len; i++)
        begin
            if (kind < 2)
            begin
                x = $urandom;
                y = $urandom;
            end
            else if (kind < 4 && $urandom_range(3) == 0)
                ;   // repeat the point
            else if (kind < 5 && $urandom_range(2) == 0)
            begin
                x = x - $urandom_range(step);
                y = y - $urandom_range(step);
            end
            else
            begin
                x = x + int'($urandom_range(2 * step)) - step;
                y = y + int'($urandom_range(2 * step)) - step;
            end
            add_point(x, y, i == len - 1);
        end
    endtask

    initial
    begin
        int pct[8] = '{0, 60, 26, 0, 60, 26, 0, 60};
        int added, len;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(pjn_pkg::REG_REVERSE, ph[0]);
            write_reg(pjn_pkg::REG_OPEN, ph[1]);
            write_reg(pjn_pkg::REG_INTERIOR, ph[2]);
            if (ph == 5)
                write_reg(REG_SPARE, 1'b1);
            idle_pct = pct[ph];
            if (ph == 0 || ph == 3 || ph == 7)
                add_directed();
            if (ph == 3)
                add_run(pjn_pkg::MAX_VERTS + 2);
            added = 0;
            while (added < 10)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(pjn_pkg::MAX_VERTS, 9)
                                               : $urandom_range(8, 1);
                add_run(len);
                added += len;
            end
            wait (pending_points.size() == 0 && !start && expected_joins.size() == 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        if (errors == 0 && expected_joins.size() == 0)
            $display("polyline_join_normals verification clean");
        else
            $display("polyline_join_normals verification failed");
        $finish;
    end
endmodule
